### hdl/ppm_pkg.sv
// Shared types and constants for the pairwise proximity monitor.
// No dependencies; used by the top level.
package ppm_pkg;

    // Command codes on the input channel
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // Result kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Configuration register indexes
    localparam logic [3:0] CFG_THRESHOLD = 4'd0;
    localparam logic [3:0] CFG_ACTIVE    = 4'd1;

    // Register reset values
    localparam logic [15:0] THRESHOLD_RESET = 16'd256;
    localparam logic [3:0]  ACTIVE_RESET    = 4'd8;

    // Event limit per scan
    localparam logic [4:0] EVENT_CAP = 5'd28;

    // Coordinate axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Scan sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ROW     = 9'b000000010,
        ST_ROWWAIT = 9'b000000100,
        ST_PAIR    = 9'b000001000,
        ST_LOAD    = 9'b000010000,
        ST_SUB     = 9'b000100000,
        ST_SQR     = 9'b001000000,
        ST_CMP     = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

endpackage

### hdl/ppm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ppm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/pairwise_proximity_monitor_unit.sv
// Pairwise proximity monitor: top level with the scan sequencer.
// Depends on ppm_pkg and ppm_ram (agent position and pair warned memories).
// Scan: a position update yields no result. A check tick reads the position of each
//   row led by a valid agent and passes over other rows and skipped pairs; each
//   active pair takes a memory read, three subtract/square steps on the shared
//   squaring multiplier and a compare, and the done item ends the scan, which is
//   held when the result channel stalls.
// Throughput: one transaction at a time; the next is taken once the scan ends.
// Reset: asynchronous, clears valid marks and warned marks, restores configuration reset values.
module pairwise_proximity_monitor_unit #(
    parameter int MAX_AGENTS = 8,
    parameter int COORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input item channel
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               command,
    input  logic [2:0]         agent_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic               kind,
    output logic [2:0]         first_agent,
    output logic [2:0]         second_agent,
    output logic [33:0]        distance_squared,
    output logic [4:0]         new_events,
    output logic               last
);

    // Derived sizes
    localparam int PAIRS = MAX_AGENTS * (MAX_AGENTS - 1) / 2;
    localparam int AW    = $clog2(MAX_AGENTS);          // agent address
    localparam int CW    = AW + 1;                      // agent counters
    localparam int SW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int PW    = 3 * COORD_BITS;              // packed {z, y, x}
    localparam int DW    = COORD_BITS + 1;              // coordinate difference
    localparam int ACCW  = 2 * DW + 2;                  // sum of three squares
    localparam int CMPW  = (ACCW + 2 > 36) ? ACCW + 2 : 36;

    // Configuration
    logic [15:0] thr_reg, thr_next;
    logic [3:0]  active_reg, active_next;
    logic [31:0] t2_reg, t2_next;

    // Sequencer
    ppm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [4:0]      count_reg, count_next;
    logic [1:0]      axis_reg, axis_next;

    // Datapath
    logic [PW-1:0]   pi_reg, pi_next;
    logic [PW-1:0]   pj_reg, pj_next;
    logic            warned_reg, warned_next;
    logic [DW-1:0]   dabs_reg, dabs_next;
    logic [ACCW-1:0] acc_reg, acc_next;

    // State marks
    logic [MAX_AGENTS-1:0] agent_valid_reg, agent_valid_next;
    logic [PAIRS-1:0]      warned_vld_reg, warned_vld_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [2:0]  first_reg, first_next;
    logic [2:0]  second_reg, second_next;
    logic [33:0] dist_reg, dist_next;
    logic [4:0]  events_reg, events_next;
    logic        last_reg, last_next;

    // Memory ports
    logic          pos_wr_en, pos_rd_en;
    logic [AW-1:0] pos_wr_addr, pos_rd_addr;
    logic [PW-1:0] pos_wr_data, pos_rd_data;
    logic          pair_wr_en, pair_rd_en;
    logic          pair_wr_data, pair_rd_data;

    // Helpers
    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          scan_sel;
    logic                   scan_valid;
    logic                   out_free;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    logic signed [COORD_BITS-1:0] ca, cb;
    logic signed [DW-1:0]   diff;
    logic [2*DW-1:0]        sq;
    logic [CMPW-1:0]        dist_ext, t2_ext;
    logic                   dist_lt, dist_gt;

    ppm_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_AGENTS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_wr_en),
        .wr_addr (pos_wr_addr),
        .wr_data (pos_wr_data),
        .rd_en   (pos_rd_en),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    ppm_ram #(
        .WIDTH (1),
        .DEPTH (PAIRS)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (pair_wr_en),
        .wr_addr (slot_reg),
        .wr_data (pair_wr_data),
        .rd_en   (pair_rd_en),
        .rd_addr (slot_reg),
        .rd_data (pair_rd_data)
    );

    // Clip the active agent count to the table size
    assign n_eff = ({1'b0, active_reg} > 5'(MAX_AGENTS)) ? CW'(MAX_AGENTS)
                                                         : CW'(active_reg);

    // Single read of the valid marks: row agent in ROW, column agent otherwise
    assign scan_sel   = (state_reg == ppm_pkg::ST_ROW) ? i_reg : j_reg;
    assign scan_valid = (scan_sel < n_eff) && agent_valid_reg[scan_sel[AW-1:0]];

    assign out_free = !out_valid_reg || result_ready;

    // Coordinates wrapped or sign-extended to the stored width
    assign cx = COORD_BITS'(pos_x);
    assign cy = COORD_BITS'(pos_y);
    assign cz = COORD_BITS'(pos_z);

    // One axis difference per step
    assign ca   = $signed(pi_reg[axis_reg*COORD_BITS +: COORD_BITS]);
    assign cb   = $signed(pj_reg[axis_reg*COORD_BITS +: COORD_BITS]);
    assign diff = DW'(ca) - DW'(cb);
    assign sq   = dabs_reg * dabs_reg;

    // Threshold tests: D < T^2 and 4D > 9T^2
    assign dist_ext = CMPW'(acc_reg);
    assign t2_ext   = CMPW'(t2_reg);
    assign dist_lt  = dist_ext < t2_ext;
    assign dist_gt  = (dist_ext << 2) > (t2_ext + (t2_ext << 3));

    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == ppm_pkg::ST_IDLE);

    always_comb
    begin
        thr_next         = thr_reg;
        active_next      = active_reg;
        t2_next          = t2_reg;
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        slot_next        = slot_reg;
        count_next       = count_reg;
        axis_next        = axis_reg;
        pi_next          = pi_reg;
        pj_next          = pj_reg;
        warned_next      = warned_reg;
        dabs_next        = dabs_reg;
        acc_next         = acc_reg;
        agent_valid_next = agent_valid_reg;
        warned_vld_next  = warned_vld_reg;
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        dist_next        = dist_reg;
        events_next      = events_reg;
        last_next        = last_reg;

        pos_wr_en    = 1'b0;
        pos_wr_addr  = AW'(agent_index);
        pos_wr_data  = {cz, cy, cx};
        pos_rd_en    = 1'b0;
        pos_rd_addr  = i_reg[AW-1:0];
        pair_wr_en   = 1'b0;
        pair_wr_data = 1'b0;
        pair_rd_en   = 1'b0;

        // Drop the result once the transaction completes
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_index == ppm_pkg::CFG_THRESHOLD)
            begin
                thr_next = cfg_data;
            end
            else if (cfg_index == ppm_pkg::CFG_ACTIVE)
            begin
                active_next = cfg_data[3:0];
            end
        end

        case (state_reg)
            ppm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (command == ppm_pkg::CMD_UPDATE)
                    begin
                        // Store the position; indexes past the table are ignored
                        if (32'(agent_index) < MAX_AGENTS)
                        begin
                            pos_wr_en = 1'b1;
                            agent_valid_next[pos_wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        t2_next    = thr_reg * thr_reg;
                        i_next     = '0;
                        j_next     = CW'(1);
                        slot_next  = '0;
                        count_next = '0;
                        state_next = ppm_pkg::ST_ROW;
                    end
                end
            end

            ppm_pkg::ST_ROW:
            begin
                if (i_reg >= CW'(MAX_AGENTS - 1))
                begin
                    state_next = ppm_pkg::ST_DONE;
                end
                else if (scan_valid)
                begin
                    pos_rd_en   = 1'b1;
                    pos_rd_addr = i_reg[AW-1:0];
                    state_next  = ppm_pkg::ST_ROWWAIT;
                end
                else
                begin
                    // Skip the whole row of pair slots
                    slot_next = slot_reg + SW'(MAX_AGENTS - 1) - SW'(i_reg);
                    i_next    = i_reg + CW'(1);
                    j_next    = i_reg + CW'(2);
                end
            end

            ppm_pkg::ST_ROWWAIT:
            begin
                pi_next    = pos_rd_data;
                state_next = ppm_pkg::ST_PAIR;
            end

            ppm_pkg::ST_PAIR:
            begin
                if (scan_valid)
                begin
                    pos_rd_en   = 1'b1;
                    pos_rd_addr = j_reg[AW-1:0];
                    pair_rd_en  = 1'b1;
                    state_next  = ppm_pkg::ST_LOAD;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                    if (j_reg == CW'(MAX_AGENTS - 1))
                    begin
                        i_next     = i_reg + CW'(1);
                        j_next     = i_reg + CW'(2);
                        state_next = ppm_pkg::ST_ROW;
                    end
                    else
                    begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end

            ppm_pkg::ST_LOAD:
            begin
                // A slot never written since reset reads as clear
                pj_next     = pos_rd_data;
                warned_next = pair_rd_data & warned_vld_reg[slot_reg];
                axis_next   = ppm_pkg::AXIS_X;
                acc_next    = '0;
                state_next  = ppm_pkg::ST_SUB;
            end

            ppm_pkg::ST_SUB:
            begin
                dabs_next  = diff[DW-1] ? DW'(-diff) : DW'(diff);
                state_next = ppm_pkg::ST_SQR;
            end

            ppm_pkg::ST_SQR:
            begin
                acc_next = acc_reg + ACCW'(sq);
                if (axis_reg == ppm_pkg::AXIS_Z)
                begin
                    state_next = ppm_pkg::ST_CMP;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ppm_pkg::ST_SUB;
                end
            end

            ppm_pkg::ST_CMP:
            begin
                logic advance;
                advance = 1'b1;
                if (dist_lt)
                begin
                    if (!warned_reg && (count_reg < ppm_pkg::EVENT_CAP))
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = ppm_pkg::KIND_EVENT;
                            first_next     = 3'(i_reg);
                            second_next    = 3'(j_reg);
                            dist_next      = 34'(acc_reg);
                            events_next    = '0;
                            last_next      = 1'b0;
                            count_next     = count_reg + 5'd1;
                            pair_wr_en     = 1'b1;
                            pair_wr_data   = 1'b1;
                            warned_vld_next[slot_reg] = 1'b1;
                        end
                        else
                        begin
                            // Hold until the result register frees up
                            advance = 1'b0;
                        end
                    end
                end
                else if (dist_gt)
                begin
                    // Past the hysteresis band: clear the warned mark
                    pair_wr_en   = 1'b1;
                    pair_wr_data = 1'b0;
                    warned_vld_next[slot_reg] = 1'b1;
                end

                if (advance)
                begin
                    slot_next = slot_reg + SW'(1);
                    if (j_reg == CW'(MAX_AGENTS - 1))
                    begin
                        i_next     = i_reg + CW'(1);
                        j_next     = i_reg + CW'(2);
                        state_next = ppm_pkg::ST_ROW;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = ppm_pkg::ST_PAIR;
                    end
                end
            end

            ppm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = ppm_pkg::KIND_DONE;
                    first_next     = '0;
                    second_next    = '0;
                    dist_next      = '0;
                    events_next    = count_reg;
                    last_next      = 1'b1;
                    state_next     = ppm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ppm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= ppm_pkg::THRESHOLD_RESET;
            active_reg      <= ppm_pkg::ACTIVE_RESET;
            state_reg       <= ppm_pkg::ST_IDLE;
            agent_valid_reg <= '0;
            warned_vld_reg  <= '0;
            out_valid_reg   <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            thr_reg         <= thr_next;
            active_reg      <= active_next;
            state_reg       <= state_next;
            agent_valid_reg <= agent_valid_next;
            warned_vld_reg  <= warned_vld_next;
            out_valid_reg   <= out_valid_next;
            count_reg       <= count_next;
        end
    end

    // Datapath and payload
    always_ff @(posedge clk)
    begin
        t2_reg      <= t2_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        slot_reg    <= slot_next;
        axis_reg    <= axis_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        warned_reg  <= warned_next;
        dabs_reg    <= dabs_next;
        acc_reg     <= acc_next;
        kind_reg    <= kind_next;
        first_reg   <= first_next;
        second_reg  <= second_next;
        dist_reg    <= dist_next;
        events_reg  <= events_next;
        last_reg    <= last_next;
    end

    assign result_valid     = out_valid_reg;
    assign kind             = kind_reg;
    assign first_agent      = first_reg;
    assign second_agent     = second_reg;
    assign distance_squared = dist_reg;
    assign new_events       = events_reg;
    assign last             = last_reg;

endmodule

### test/proximity_event_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the pairwise proximity monitor: mirrors agent positions, valid marks
// and warned pairs, predicts each scan's results and compares them on the result channel.
// Depends on ppm_pkg.
module proximity_event_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic               command,
    input  logic [2:0]         agent_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic               kind,
    input  logic [2:0]         first_agent,
    input  logic [2:0]         second_agent,
    input  logic [33:0]        distance_squared,
    input  logic [4:0]         new_events,
    input  logic               last,
    output int                 mismatch_count,
    output int                 outstanding
);

    localparam int NUM_AGENTS = 8;

    typedef struct {
        logic        kind;
        logic [2:0]  lo_agent;
        logic [2:0]  hi_agent;
        logic [33:0] dist_sq;
        logic [4:0]  event_total;
        logic        last;
    } scan_result_t;

    logic signed [15:0] agent_pos [NUM_AGENTS][3];
    logic               agent_seen [NUM_AGENTS];
    logic               warned [NUM_AGENTS][NUM_AGENTS];
    logic [15:0]        threshold;
    logic [3:0]         active;
    scan_result_t       expected_q [$];

    task automatic report(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    // Walk the pairs of one check tick and queue the events and the done item.
    task automatic predict_scan();
        int           span;
        int           fired;
        longint       t_sq;
        longint       d_sq;
        longint       diff;
        scan_result_t r;
        span  = (active > NUM_AGENTS) ? NUM_AGENTS : int'(active);
        t_sq  = longint'(threshold) * longint'(threshold);
        fired = 0;
        for (int i = 0; i < span; i++)
        begin
            if (!agent_seen[i])
                continue;
            for (int j = i + 1; j < span; j++)
            begin
                if (!agent_seen[j])
                    continue;
                d_sq = 0;
                for (int k = 0; k < 3; k++)
                begin
                    diff = longint'(agent_pos[i][k]) - longint'(agent_pos[j][k]);
                    d_sq += diff * diff;
                end
                if (d_sq < t_sq)
                begin
                    if (!warned[i][j] && fired < ppm_pkg::EVENT_CAP)
                    begin
                        r.kind        = ppm_pkg::KIND_EVENT;
                        r.lo_agent    = 3'(i);
                        r.hi_agent    = 3'(j);
                        r.dist_sq     = d_sq[33:0];
                        r.event_total = '0;
                        r.last        = 1'b0;
                        expected_q.insert(expected_q.size(), r);
                        warned[i][j] = 1'b1;
                        fired++;
                    end
                end
                else if (4 * d_sq > 9 * t_sq)
                begin
                    warned[i][j] = 1'b0;
                end
            end
        end
        r.kind        = ppm_pkg::KIND_DONE;
        r.lo_agent    = '0;
        r.hi_agent    = '0;
        r.dist_sq     = '0;
        r.event_total = 5'(fired);
        r.last        = 1'b1;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic check_result();
        scan_result_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result with nothing expected: kind %0d pair %0d-%0d",
                             kind, first_agent, second_agent));
            return;
        end
        want = expected_q.pop_front();
        if (kind !== want.kind)
            report($sformatf("kind got %0d, expected %0d", kind, want.kind));
        if (first_agent !== want.lo_agent)
            report($sformatf("first_agent got %0d, expected %0d",
                             first_agent, want.lo_agent));
        if (second_agent !== want.hi_agent)
            report($sformatf("second_agent got %0d, expected %0d",
                             second_agent, want.hi_agent));
        if (distance_squared !== want.dist_sq)
            report($sformatf("distance_squared got %0d, expected %0d",
                             distance_squared, want.dist_sq));
        if (new_events !== want.event_total)
            report($sformatf("new_events got %0d, expected %0d",
                             new_events, want.event_total));
        if (last !== want.last)
            report($sformatf("last got %0d, expected %0d", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AGENTS; a++)
            begin
                agent_seen[a] = 1'b0;
                for (int k = 0; k < 3; k++)
                    agent_pos[a][k] = '0;
                for (int b = 0; b < NUM_AGENTS; b++)
                    warned[a][b] = 1'b0;
            end
            threshold = ppm_pkg::THRESHOLD_RESET;
            active    = ppm_pkg::ACTIVE_RESET;
            expected_q.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ppm_pkg::CFG_THRESHOLD)
                    threshold = cfg_data;
                else if (cfg_index == ppm_pkg::CFG_ACTIVE)
                    active = cfg_data[3:0];
            end
            if (item_valid && item_ready)
            begin
                if (command == ppm_pkg::CMD_UPDATE)
                begin
                    agent_pos[agent_index][0] = pos_x;
                    agent_pos[agent_index][1] = pos_y;
                    agent_pos[agent_index][2] = pos_z;
                    agent_seen[agent_index]   = 1'b1;
                end
                else
                begin
                    predict_scan();
                end
            end
            if (result_valid && result_ready)
                check_result();
            outstanding <= expected_q.size();
        end
    end

endmodule

### test/pairwise_proximity_monitor_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for pairwise_proximity_monitor_unit: drives register writes, position
// updates and check ticks with random idling and gives the verdict.
// Depends on ppm_pkg, the block's RTL and proximity_event_checker.
module pairwise_proximity_monitor_unit_tb;

    localparam int QUIET_LIMIT   = 5000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 8;     // idle margin before a register write
    localparam int DRAIN_CYCLES  = 300;   // longer than one full scan
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 35;

    // Unmapped register index; the write must leave both registers alone.
    localparam logic [3:0] CFG_SPARE = 4'd15;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index    = '0;
    logic [15:0]        cfg_data     = '0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    logic               command      = ppm_pkg::CMD_UPDATE;
    logic [2:0]         agent_index  = '0;
    logic signed [15:0] pos_x        = '0;
    logic signed [15:0] pos_y        = '0;
    logic signed [15:0] pos_z        = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic               kind;
    logic [2:0]         first_agent;
    logic [2:0]         second_agent;
    logic [33:0]        distance_squared;
    logic [4:0]         new_events;
    logic               last;

    int mismatches;
    int outstanding;
    bit tx_gaps_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    int rx_hold     = 0;
    int quiet       = 0;

    always #5 clk = ~clk;

    pairwise_proximity_monitor_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .command          (command),
        .agent_index      (agent_index),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .kind             (kind),
        .first_agent      (first_agent),
        .second_agent     (second_agent),
        .distance_squared (distance_squared),
        .new_events       (new_events),
        .last             (last)
    );

    proximity_event_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .command          (command),
        .agent_index      (agent_index),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .kind             (kind),
        .first_agent      (first_agent),
        .second_agent     (second_agent),
        .distance_squared (distance_squared),
        .new_events       (new_events),
        .last             (last),
        .mismatch_count   (mismatches),
        .outstanding      (outstanding)
    );

    // Idle stretch length: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    // Random point within +/- spread of a center, wrapped to the 16-bit field.
    function automatic logic [15:0] near(input int center, input int spread);
        return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Present one transaction on the item channel and hold it until accepted.
    // Valid stays high afterwards; the next call replaces or drops it, settle_idle takes it down.
    task automatic push_item(input logic cmd, input logic [2:0] idx,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        agent_index <= idx;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic move_agent(input logic [2:0] idx, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
        push_item(ppm_pkg::CMD_UPDATE, idx, x, y, z);
    endtask

    // Check tick; scramble the ignored payload so its bits toggle too.
    task automatic tick();
        push_item(ppm_pkg::CMD_CHECK, 3'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    // Drop the item channel, let every expected result drain, then leave margin.
    task automatic settle_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver back-pressure: random stalls while enabled, steady ready otherwise.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
            rx_hold--;
        else if (rx_stall_on && $urandom_range(0, 3) == 0)
            rx_hold = idle_len();
        result_ready <= (rx_hold == 0);
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (cfg_valid && cfg_ready)
            || (result_valid && result_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        int          roll;
        int          spread;
        int          cx;
        int          cy;
        int          cz;
        logic [15:0] thr;
        logic [3:0]  act;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset configuration: threshold one meter, all agents.
        tick();                                         // no agent valid: done only
        move_agent(3'd0, 16'd0, 16'd0, 16'd0);
        move_agent(3'd1, 16'd100, 16'd0, 16'd0);
        tick();                                         // new close pair 0-1
        tick();                                         // already warned: silent
        move_agent(3'd2, 16'd0, 16'd256, 16'd0);        // exactly at threshold from 0
        tick();
        move_agent(3'd1, 16'd384, 16'd0, 16'd0);        // exactly 1.5x, but moved again before any tick
        move_agent(3'd1, 16'd0, 16'd0, 16'd10);
        tick();                                         // close again but still warned
        move_agent(3'd1, 16'd385, 16'd0, 16'd0);        // just past 1.5x: flag cleared
        tick();
        move_agent(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick();                                         // pair 0-1 fires again
        move_agent(3'd3, 16'h8000, 16'h8000, 16'h8000);
        move_agent(3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        tick();                                         // largest possible separation

        // Threshold extremes and agent counts outside the normal range.
        settle_idle();
        cfg_write(ppm_pkg::CFG_THRESHOLD, 16'hFFFF);
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'd15);
        tick();
        settle_idle();
        cfg_write(ppm_pkg::CFG_THRESHOLD, 16'd0);
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'd9);
        tick();
        settle_idle();
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'd1);
        tick();
        settle_idle();
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'd0);
        tick();

        // Agents above the active count are stored but sit out until included.
        settle_idle();
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'd3);
        cfg_write(ppm_pkg::CFG_THRESHOLD, ppm_pkg::THRESHOLD_RESET);
        move_agent(3'd5, 16'h5555, 16'hAAAA, 16'h5555);
        move_agent(3'd6, 16'd1, 16'd1, 16'd1);
        tick();
        settle_idle();
        cfg_write(ppm_pkg::CFG_ACTIVE, 16'(ppm_pkg::ACTIVE_RESET));
        cfg_write(CFG_SPARE, 16'hFFFF);
        tick();

        // Random part: per phase pick a setting and a cluster center, then keep
        // agents moving around it so pairs cross the threshold both ways.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle_idle();
            tx_gaps_on  = (ph % 3 != 2);
            rx_stall_on = (ph % 3 != 1);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                thr = 16'd0;
            else if (roll == 1)
                thr = 16'hFFFF;
            else
                thr = 16'($urandom_range(32, 2048));
            roll = $urandom_range(0, 9);
            act = (roll < 8) ? 4'($urandom_range(2, 8)) : 4'($urandom_range(0, 15));
            cfg_write(ppm_pkg::CFG_THRESHOLD, thr);
            cfg_write(ppm_pkg::CFG_ACTIVE, 16'(act));

            spread = 2 * int'(thr);
            if (spread < 64)
                spread = 64;
            if (spread > 30000)
                spread = 30000;
            cx = int'($urandom_range(0, 40000)) - 20000;
            cy = int'($urandom_range(0, 40000)) - 20000;
            cz = int'($urandom_range(0, 40000)) - 20000;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    tick();
                else if (roll < 89)
                    move_agent(3'($urandom), near(cx, spread), near(cy, spread),
                               near(cz, spread));
                else
                    move_agent(3'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
            end
            tick();
        end

        // Drain: wait out every expected result, then a full scan's worth of cycles.
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
